// ----- rtl/core/preemptive_priority_scheduler_top_macros.svh -----
// Assertion macros shared by the scheduler RTL
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset
`define PPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  `PPS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/pps_pkg.sv -----
// Package with types, constants and codes of the priority scheduler
`timescale 1ns / 1ps
package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int PRIO_W    = 8;

  // Stream widths, padded to whole bytes
  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

  localparam logic [TIME_BITS-1:0] TIME_ONES = {TIME_BITS{1'b1}};

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PRIO_W-1:0]    prio_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ALU_SUB,
    ALU_DEC,
    ALU_INC
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DEC,
    ST_ADV,
    ST_TAT,
    ST_WT,
    ST_EMIT
  } state_e;

  // Step strobes from the sequencer to the datapath
  typedef struct packed {
    logic idle;
    logic dispatch;
    logic scan;
    logic dec;
    logic adv;
    logic tat;
    logic wt;
    logic emit;
  } ctrl_t;

endpackage

// ----- rtl/core/preemptive_priority_scheduler_top.sv -----
// Top level of the tick-driven preemptive priority scheduler
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid_i/tready_o      tuser: command, tdata: load fields
//  m_axis   out  m_axis_tvalid_o/tready_i      tdata: per-item report
//
// A tick steps through accept, dispatch, a scan of each task slot in turn,
// decrement, time advance, turnaround, waiting and emit; a tick that
// completes no task skips turnaround and waiting. Clear, load and no-op
// items go from dispatch straight to emit. Reset empties the task table and
// zeroes time; no input is taken while an item is in work, and an unread
// report holds the emit step until taken.
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_top_macros.svh"
module preemptive_priority_scheduler_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [3:0] entry_index, [19:4] arrival, [35:20] burst, [43:36] prio_level
  input  logic [pps_pkg::IN_W-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]                s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [0] ran, [4:1] running_index, [5] switched, [6] finished,
  // [22:7] turnaround, [38:23] waiting, [54:39] now_time
  output logic [pps_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import pps_pkg::*;

  ctrl_t   ctl;
  idx_t    scan_idx;
  logic    s_accept;
  logic    out_free;

  // Latched command
  cmd_e    cmd_q;
  logic [3:0] slot_q;
  time_t   arr_in_q, burst_in_q;
  prio_t   prio_in_q;

  // Task table
  time_t   arr_tab_q   [MAX_TASKS];
  time_t   burst_tab_q [MAX_TASKS];
  time_t   rem_tab_q   [MAX_TASKS];
  prio_t   prio_tab_q  [MAX_TASKS];
  logic [MAX_TASKS-1:0] loaded_q;

  // Scheduler state
  time_t   time_q;
  idx_t    last_q;
  logic    last_vld_q;

  // Best candidate of the current scan
  logic    found_q;
  idx_t    best_idx_q;
  prio_t   best_prio_q;
  time_t   best_arr_q, best_burst_q, best_rem_q;

  // Report fields
  logic    sw_q, fin_q;
  time_t   tat_q, wt_q;
  logic                m_valid_q;
  logic [OUT_W-1:0]    m_data_q;

  // Shared unit
  alu_op_e alu_op;
  time_t   alu_a, alu_b, alu_res;
  logic    alu_co;

  logic    load_ok;
  logic    cand_ready;
  logic    rem_wr;
  idx_t    rem_wr_idx;
  time_t   rem_wr_data;

  function automatic logic rem_rd_nz(input time_t v);
    return (v != '0);
  endfunction

  assign s_axis_tready_o = ctl.idle;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_accept_i (s_accept),
    .cmd_i      (cmd_q),
    .finish_i   (found_q && fin_q),
    .out_free_i (out_free),
    .ctrl_o     (ctl),
    .scan_idx_o (scan_idx)
  );

  pps_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .co_o  (alu_co)
  );

  // Route operands to the shared unit by step
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = time_q;
    alu_b  = arr_tab_q[scan_idx];
    if (ctl.dec) begin
      alu_op = ALU_DEC;
      alu_a  = best_rem_q;
    end else if (ctl.adv) begin
      alu_op = ALU_INC;
      alu_a  = time_q;
    end else if (ctl.tat) begin
      alu_b  = best_arr_q;
    end else if (ctl.wt) begin
      alu_a  = tat_q;
      alu_b  = best_burst_q;
    end
  end

  assign load_ok    = ctl.dispatch && (cmd_q == CMD_LOAD) && (32'(slot_q) < MAX_TASKS);
  assign cand_ready = loaded_q[scan_idx] && (rem_rd_nz(rem_tab_q[scan_idx])) && alu_co;

  // One write port on the remaining-work column
  always_comb begin
    rem_wr      = 1'b0;
    rem_wr_idx  = IDX_W'(slot_q);
    rem_wr_data = burst_in_q;
    if (load_ok) begin
      rem_wr = 1'b1;
    end else if (ctl.dec && found_q) begin
      rem_wr      = 1'b1;
      rem_wr_idx  = best_idx_q;
      rem_wr_data = alu_res;
    end
  end

  // Capture the item on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_NOP;
    end else if (s_accept) begin
      cmd_q <= cmd_e'(s_axis_tuser_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      slot_q     <= s_axis_tdata_i[3:0];
      arr_in_q   <= TIME_BITS'(s_axis_tdata_i[19:4]);
      burst_in_q <= TIME_BITS'(s_axis_tdata_i[35:20]);
      prio_in_q  <= s_axis_tdata_i[43:36];
    end
  end

  // Table columns
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      arr_tab_q[IDX_W'(slot_q)]   <= arr_in_q;
      burst_tab_q[IDX_W'(slot_q)] <= burst_in_q;
      prio_tab_q[IDX_W'(slot_q)]  <= prio_in_q;
    end
    if (rem_wr) begin
      rem_tab_q[rem_wr_idx] <= rem_wr_data;
    end
  end

  // Loaded flags, time and last runner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      time_q     <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
    end else if (ctl.dispatch && cmd_q == CMD_CLEAR) begin
      loaded_q   <= '0;
      time_q     <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
    end else if (load_ok) begin
      loaded_q[IDX_W'(slot_q)] <= 1'b1;
    end else if (ctl.adv) begin
      if (!alu_co) begin
        time_q <= alu_res;
      end
      last_q     <= found_q ? best_idx_q : last_q;
      last_vld_q <= found_q;
    end
  end

  // Scan, decrement and report arithmetic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      best_idx_q <= '0;
      sw_q       <= 1'b0;
      fin_q      <= 1'b0;
      tat_q      <= '0;
      wt_q       <= '0;
    end else if (ctl.dispatch) begin
      found_q    <= 1'b0;
      best_idx_q <= '0;
      sw_q       <= 1'b0;
      fin_q      <= 1'b0;
      tat_q      <= '0;
      wt_q       <= '0;
    end else if (ctl.scan) begin
      if (cand_ready && (!found_q || prio_tab_q[scan_idx] < best_prio_q)) begin
        found_q    <= 1'b1;
        best_idx_q <= scan_idx;
      end
    end else if (ctl.dec) begin
      fin_q <= found_q && (alu_res == '0);
    end else if (ctl.adv) begin
      sw_q <= found_q && (!last_vld_q || last_q != best_idx_q);
    end else if (ctl.tat) begin
      tat_q <= alu_res;
    end else if (ctl.wt) begin
      wt_q <= alu_co ? alu_res : '0;
    end
  end

  // Fields of the best candidate
  always_ff @(posedge clk_i) begin
    if (ctl.scan && cand_ready && (!found_q || prio_tab_q[scan_idx] < best_prio_q)) begin
      best_prio_q  <= prio_tab_q[scan_idx];
      best_arr_q   <= arr_tab_q[scan_idx];
      best_burst_q <= burst_tab_q[scan_idx];
      best_rem_q   <= rem_tab_q[scan_idx];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl.emit && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit && out_free) begin
      m_data_q <= {1'b0, 16'(time_q), 16'(wt_q), 16'(tat_q), fin_q, sw_q,
                   4'(best_idx_q), found_q};
    end
  end

  // A switch or a completion is only reported for a tick that ran a task
  `PPS_ASSERT(a_switch_needs_run, m_axis_tvalid_o && m_axis_tdata_o[5] |-> m_axis_tdata_o[0],
              "switched reported without a running task")
  `PPS_ASSERT(a_finish_needs_run, m_axis_tvalid_o && m_axis_tdata_o[6] |-> m_axis_tdata_o[0],
              "finished reported without a running task")
  // Time only moves backward on a clear
  `PPS_ASSERT(a_time_monotonic,
              !$past(ctl.dispatch && cmd_q == CMD_CLEAR) |-> time_q >= $past(time_q),
              "time went backward without a clear")
  // An accepted item always goes to dispatch next
  `PPS_ASSERT_NEXT(a_accept_dispatch, s_accept, ctl.dispatch,
                   "accepted item not dispatched")

endmodule

// ----- rtl/core/pps_alu.sv -----
// Shared adder/subtractor used for every time and count update
`timescale 1ns / 1ps
module pps_alu (
  input  pps_pkg::alu_op_e op_i,
  input  pps_pkg::time_t   a_i,
  input  pps_pkg::time_t   b_i,
  output pps_pkg::time_t   res_o,
  output logic             co_o   // SUB: a >= b, DEC: a != 0, INC: overflow
);
  import pps_pkg::*;

  time_t                operand;
  logic                 cin;
  logic [TIME_BITS:0]   sum;

  // Pick the second operand and carry in for the operation
  always_comb begin
    case (op_i)
      ALU_SUB: begin
        operand = ~b_i;
        cin     = 1'b1;
      end
      ALU_DEC: begin
        operand = TIME_ONES;
        cin     = 1'b0;
      end
      ALU_INC: begin
        operand = '0;
        cin     = 1'b1;
      end
      default: begin
        operand = '0;
        cin     = 1'b0;
      end
    endcase
  end

  assign sum   = {1'b0, a_i} + {1'b0, operand} + {{TIME_BITS{1'b0}}, cin};
  assign res_o = sum[TIME_BITS-1:0];
  assign co_o  = sum[TIME_BITS];

endmodule

// ----- rtl/core/pps_ctrl.sv -----
// Sequencer that walks one command through dispatch, scan and update steps
`timescale 1ns / 1ps
module pps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_accept_i,
  input  pps_pkg::cmd_e   cmd_i,
  input  logic            finish_i,
  input  logic            out_free_i,
  output pps_pkg::ctrl_t  ctrl_o,
  output pps_pkg::idx_t   scan_idx_o
);
  import pps_pkg::*;

  state_e state_q, state_d;
  idx_t   scan_idx_q, scan_idx_d;
  logic   scan_last;

  assign scan_last  = (scan_idx_q == IDX_W'(MAX_TASKS - 1));
  assign scan_idx_o = scan_idx_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_accept_i) state_d = ST_DISPATCH;
      ST_DISPATCH: state_d = (cmd_i == CMD_TICK) ? ST_SCAN : ST_EMIT;
      ST_SCAN:     if (scan_last) state_d = ST_DEC;
      ST_DEC:      state_d = ST_ADV;
      ST_ADV:      state_d = finish_i ? ST_TAT : ST_EMIT;
      ST_TAT:      state_d = ST_WT;
      ST_WT:       state_d = ST_EMIT;
      ST_EMIT:     if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Step strobes
  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE:     ctrl_o.idle     = 1'b1;
      ST_DISPATCH: ctrl_o.dispatch = 1'b1;
      ST_SCAN:     ctrl_o.scan     = 1'b1;
      ST_DEC:      ctrl_o.dec      = 1'b1;
      ST_ADV:      ctrl_o.adv      = 1'b1;
      ST_TAT:      ctrl_o.tat      = 1'b1;
      ST_WT:       ctrl_o.wt       = 1'b1;
      ST_EMIT:     ctrl_o.emit     = 1'b1;
      default:     ctrl_o          = '0;
    endcase
  end

  // Restart the slot counter on dispatch, advance it while scanning
  always_comb begin
    scan_idx_d = scan_idx_q;
    if (state_q == ST_DISPATCH) begin
      scan_idx_d = '0;
    end else if (state_q == ST_SCAN && !scan_last) begin
      scan_idx_d = scan_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the preemptive priority scheduler over its item streams
`timescale 1ns / 1ps
module testbench;
  import pps_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct {
    cmd_e  cmd;
    idx_t  slot;
    time_t arrival;
    time_t burst;
    prio_t prio;
  } sched_item_t;

  // Packed from the top bit down, so ran lands in bit 0
  typedef struct packed {
    time_t now_time;
    time_t waiting;
    time_t turnaround;
    logic  finished;
    logic  switched;
    idx_t  runner;
    logic  ran;
  } sched_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_valid = 1'b0;
  logic [IN_W-1:0]  s_data  = '0;
  logic [1:0]       s_user  = CMD_CLEAR;
  logic             s_ready;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;

  sched_item_t   pending_items[$];
  sched_report_t expected_reports[$];
  sched_item_t   sent_item;

  // Scheduler state as the testbench sees it
  time_t tbl_arrival [MAX_TASKS];
  time_t tbl_burst   [MAX_TASKS];
  time_t tbl_left    [MAX_TASKS];
  prio_t tbl_prio    [MAX_TASKS];
  bit    tbl_loaded  [MAX_TASKS];
  time_t sched_now;
  idx_t  prev_runner;
  bit    prev_runner_valid;

  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  bit          hold_trigger = 1'b0;
  bit          idle_mode    = 1'b1;
  int unsigned error_count  = 0;

  preemptive_priority_scheduler_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // Free-running clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #250_000_000;
    $display("status: fail");
    $finish;
  end

  // Empty the task table, zero time and forget the last runner
  function automatic void sched_clear();
    for (int i = 0; i < MAX_TASKS; i++) begin
      tbl_arrival[i] = '0;
      tbl_burst[i]   = '0;
      tbl_left[i]    = '0;
      tbl_prio[i]    = '0;
      tbl_loaded[i]  = 1'b0;
    end
    sched_now         = '0;
    prev_runner       = '0;
    prev_runner_valid = 1'b0;
  endfunction

  // Apply one item to the state and work out the report it gives
  function automatic sched_report_t sched_predict(sched_item_t it);
    sched_report_t r;
    int            best;
    prio_t         best_prio;
    r = '0;
    best = -1;
    best_prio = '0;
    case (it.cmd)
      CMD_CLEAR: sched_clear();
      CMD_LOAD: begin
        tbl_arrival[it.slot] = it.arrival;
        tbl_burst[it.slot]   = it.burst;
        tbl_left[it.slot]    = it.burst;
        tbl_prio[it.slot]    = it.prio;
        tbl_loaded[it.slot]  = 1'b1;
      end
      CMD_TICK: begin
        // Lowest priority number among ready tasks, lowest slot on a tie
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (tbl_loaded[i] && tbl_left[i] != '0 && tbl_arrival[i] <= sched_now) begin
            if (best < 0 || tbl_prio[i] < best_prio) begin
              best = i;
              best_prio = tbl_prio[i];
            end
          end
        end
        if (sched_now != TIME_ONES) sched_now = sched_now + 1'b1;
        if (best >= 0) begin
          r.ran      = 1'b1;
          r.runner   = idx_t'(best);
          r.switched = !prev_runner_valid || prev_runner != idx_t'(best);
          tbl_left[best] = tbl_left[best] - 1'b1;
          if (tbl_left[best] == '0) begin
            r.finished   = 1'b1;
            r.turnaround = sched_now - tbl_arrival[best];
            r.waiting    = (r.turnaround >= tbl_burst[best]) ?
                           r.turnaround - tbl_burst[best] : '0;
          end
          prev_runner       = idx_t'(best);
          prev_runner_valid = 1'b1;
        end else begin
          prev_runner_valid = 1'b0;
        end
      end
      default: ;
    endcase
    r.now_time = sched_now;
    return r;
  endfunction

  // Pick an idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_mode) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic log_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic queue_item(cmd_e cmd, int unsigned slot, int unsigned arrival,
                            int unsigned burst, int unsigned prio);
    sched_item_t it;
    it.cmd     = cmd;
    it.slot    = idx_t'(slot);
    it.arrival = time_t'(arrival);
    it.burst   = time_t'(burst);
    it.prio    = prio_t'(prio);
    pending_items.push_back(it);
  endtask

  // Non-load command with random payload that the block must ignore
  task automatic queue_cmd(cmd_e cmd);
    queue_item(cmd, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_items.size() != 0 || s_valid || expected_reports.size() != 0)
      @(negedge clk_i);
  endtask

  // Input side: offer queued items, idle between them at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_data   <= '0;
      s_user   <= CMD_CLEAR;
      send_gap <= 0;
    end else begin
      if (s_valid && s_ready) expected_reports.push_back(sched_predict(sent_item));
      if (!s_valid || s_ready) begin
        if (send_gap != 0) begin
          s_valid  <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
          sent_item = pending_items.pop_front();
          s_valid  <= 1'b1;
          s_data   <= {4'b0, sent_item.prio, sent_item.burst, sent_item.arrival, sent_item.slot};
          s_user   <= sent_item.cmd;
          send_gap <= pick_gap();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted down on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_trigger) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output side: take reports, stall at random, compare with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    sched_report_t got;
    sched_report_t want;
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_valid && m_ready) begin
        got = m_data[54:0];
        if (expected_reports.size() == 0) begin
          log_mismatch("unexpected report, now_time", got.now_time, 0);
        end else begin
          want = expected_reports.pop_front();
          if (got.ran != want.ran) log_mismatch("ran", got.ran, want.ran);
          if (got.runner != want.runner) log_mismatch("running_index", got.runner, want.runner);
          if (got.switched != want.switched) log_mismatch("switched", got.switched, want.switched);
          if (got.finished != want.finished) log_mismatch("finished", got.finished, want.finished);
          if (got.turnaround != want.turnaround)
            log_mismatch("turnaround", got.turnaround, want.turnaround);
          if (got.waiting != want.waiting) log_mismatch("waiting", got.waiting, want.waiting);
          if (got.now_time != want.now_time) log_mismatch("now_time", got.now_time, want.now_time);
        end
      end
      if (hold_left > 1) begin
        m_ready <= 1'b0;
      end else if (stall_left != 0) begin
        m_ready    <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_ready    <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Stimulus: directed cases, then random episodes
  initial begin
    int unsigned random_count;
    int unsigned tick_est;
    int unsigned n_loads;
    int unsigned n_steps;
    int unsigned r;
    bit          hold_done;

    sched_clear();
    random_count = 0;
    tick_est = 0;
    hold_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle tick, tie on priority, zero burst, late arrival, reload, clear
    queue_cmd(CMD_NOP);
    queue_cmd(CMD_TICK);
    queue_item(CMD_LOAD, 0, 0, 2, 5);
    queue_item(CMD_LOAD, 15, 0, 1, 5);
    queue_item(CMD_LOAD, 7, 0, 0, 0);
    queue_cmd(CMD_TICK);
    queue_item(CMD_LOAD, 3, 2, 1, 0);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_TICK);
    queue_item(CMD_LOAD, 4, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_item(CMD_LOAD, 5, 0, 3, 1);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_TICK);
    queue_item(CMD_LOAD, 5, 0, 1, 1);
    queue_cmd(CMD_TICK);
    queue_cmd(CMD_TICK);
    queue_item(CMD_CLEAR, 15, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_cmd(CMD_TICK);
    queue_item(CMD_NOP, 15, 16'hFFFF, 16'hFFFF, 8'hFF);
    wait_drained();

    // Random episodes, mostly well-formed task sets followed by ticks
    while (random_count < RANDOM_ITEMS) begin
      @(negedge clk_i);
      while (pending_items.size() != 0) @(negedge clk_i);
      idle_mode = ($urandom_range(3) != 0);
      r = $urandom_range(99);
      if (r < 12) begin
        // Noise: any command with any payload
        for (int i = 0; i < 10; i++) begin
          queue_item(cmd_e'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
          random_count++;
        end
        tick_est = 0;
      end else begin
        if ($urandom_range(9) < 7) begin
          queue_cmd(CMD_CLEAR);
          random_count++;
          tick_est = 0;
        end
        n_loads = $urandom_range(6, 1);
        for (int i = 0; i < n_loads; i++) begin
          queue_item(CMD_LOAD, $urandom_range(15), tick_est + $urandom_range(8),
                     ($urandom_range(9) == 0) ? 0 : $urandom_range(10, 1),
                     $urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
          random_count++;
        end
        n_steps = $urandom_range(60, 15);
        for (int i = 0; i < n_steps; i++) begin
          r = $urandom_range(19);
          if (r < 2) begin
            queue_item(CMD_LOAD, $urandom_range(15), tick_est + $urandom_range(4),
                       $urandom_range(8, 1), $urandom_range(3));
            random_count++;
          end else if (r == 2) begin
            queue_cmd(CMD_NOP);
            random_count++;
          end else begin
            queue_cmd(CMD_TICK);
            random_count++;
            tick_est++;
          end
        end
      end
      // Stall the output for a long stretch while items keep coming
      if (!hold_done && random_count >= 600) begin
        hold_done = 1'b1;
        @(negedge clk_i);
        hold_trigger = 1'b1;
        @(negedge clk_i);
        hold_trigger = 1'b0;
      end
    end

    // Drain, let the last item settle, then decide
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pps_pkg.sv
rtl/core/pps_alu.sv
rtl/core/pps_ctrl.sv
rtl/core/preemptive_priority_scheduler_top.sv
tb/testbench.sv
